// ===== rtl/gpw_pkg.sv =====
package gpw_pkg;

    // one-hot sequencer states
    typedef enum logic [13:0] {
        S_CLEAR = 14'b00000000000001,
        S_IDLE  = 14'b00000000000010,
        S_PRD   = 14'b00000000000100,
        S_PEV   = 14'b00000000001000,
        S_PWR   = 14'b00000000010000,
        S_QRD   = 14'b00000000100000,
        S_QEV   = 14'b00000001000000,
        S_WLOAD = 14'b00000010000000,
        S_WSEG  = 14'b00000100000000,
        S_WRD   = 14'b00001000000000,
        S_WEV   = 14'b00010000000000,
        S_WIDA  = 14'b00100000000000,
        S_WIDB  = 14'b01000000000000,
        S_WIDC  = 14'b10000000000000
    } state_t;

    // pass of the wire walker
    typedef enum logic [1:0] {
        WM_MEASURE = 2'd0,
        WM_CHECK   = 2'd1,
        WM_WRITE   = 2'd2
    } walk_mode_t;

    localparam logic [1:0] OP_PLACE  = 2'd0;
    localparam logic [1:0] OP_ANCHOR = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_ID      = 3'd1;
    localparam logic [2:0] ST_BLOCKED    = 3'd2;
    localparam logic [2:0] ST_CONFLICT   = 3'd3;
    localparam logic [2:0] ST_BAD_ANCHOR = 3'd4;

endpackage

// ===== rtl/gpw_ram.sv =====
module gpw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/grid_part_and_wire_placer.sv =====
// grid of cells, each holding a part id (low byte) and a wire id (high byte)
// command channel: a transaction is taken when start is high and busy is low;
//   op selects place part, wire anchor point or query cell
// result channel: done pulses for one cycle with ok, status, given_id,
//   cell_part and cell_wire; the receiver cannot stall, so nothing waits
// a wire anchor that is not the last one is stored while the buffer has room, no result
// query: the cell is read (S_QRD) and evaluated (S_QEV); off grid, zeros are returned from idle
// place: each cell is read (S_PRD) and checked (S_PEV) for being free, then each cell
//   is written (S_PWR); the single port of the cell memory sets this
// wire: a measure pass over the anchors (S_WSEG), then a check pass and a write pass
//   that each read (S_WRD) and evaluate (S_WEV) every walked cell, plus S_WIDA to S_WIDC to
//   fetch the inherited id; all limited by the one cell memory port
// one item is in flight at a time; busy stays high until its result leaves
// after reset a clearing pass writes zero to all GRID_SIDE*GRID_SIDE cells,
//   one per cycle, with busy high; part and wire ids restart at 1
module grid_part_and_wire_placer #(
    parameter int GRID_SIDE   = 256,
    parameter int MAX_PART    = 16,
    parameter int MAX_ANCHORS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] op,
    input  logic [7:0] cell_x,
    input  logic [7:0] cell_y,
    input  logic [4:0] part_width,
    input  logic [4:0] part_height,
    input  logic [7:0] wire_id,
    input  logic       last_point,
    output logic       done,
    output logic       ok,
    output logic [2:0] status,
    output logic [7:0] given_id,
    output logic [7:0] cell_part,
    output logic [7:0] cell_wire
);
    import gpw_pkg::*;

    localparam int DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int AIW   = $clog2(MAX_ANCHORS + 1);
    localparam int ANW   = $clog2(MAX_ANCHORS);
    localparam int PW    = $clog2(MAX_PART + 1);
    localparam int TW    = $clog2(MAX_ANCHORS * 256 + 1);

    // control state
    state_t           state_reg, state_next;
    walk_mode_t       mode_reg, mode_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic [8:0]       next_part_reg, next_part_next;
    logic [8:0]       next_wire_reg, next_wire_next;
    logic [AIW-1:0]   cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    logic [AIW-1:0]   k_reg, k_next;
    logic [TW-1:0]    idx_reg, idx_next;
    logic [TW-1:0]    total_reg, total_next;
    logic             first_reg, first_next;
    logic             last_reg, last_next;
    logic             bad_reg, bad_next;
    logic             done_reg;

    // payload
    logic [7:0]       ax_reg, ax_next, ay_reg, ay_next;
    logic [7:0]       cx_reg, cx_next, cy_reg, cy_next;
    logic [7:0]       fx_reg, fx_next, fy_reg, fy_next;
    logic             xinc_reg, xinc_next, xdec_reg, xdec_next;
    logic             yinc_reg, yinc_next, ydec_reg, ydec_next;
    logic [7:0]       rem_reg, rem_next;
    logic [PW-1:0]    ox_reg, ox_next, oy_reg, oy_next;
    logic [PW-1:0]    w_reg, w_next, h_reg, h_next;
    logic [7:0]       id_reg, id_next;
    logic             ok_reg;
    logic [2:0]       status_reg;
    logic [7:0]       given_reg, cp_reg, cw_reg;
    logic [7:0]       anch_x_reg [MAX_ANCHORS];
    logic [7:0]       anch_y_reg [MAX_ANCHORS];

    // cell memory port
    logic             ram_we;
    logic [AW-1:0]    ram_addr;
    logic [15:0]      ram_wdata;
    logic [15:0]      ram_rdata;

    // result to register
    logic             res_fire;
    logic [2:0]       res_status;
    logic [7:0]       res_given, res_cp, res_cw;

    logic             anch_we;
    logic             wire_end;
    logic [AIW-1:0]   cnt_new;
    logic             ovf_new;
    logic [AIW-1:0]   kp1;
    logic [7:0]       nx, ny, dx, dy, nlen;
    logic             seg_bad;
    logic [7:0]       px, py;
    logic             p_last_y, p_done;
    logic [7:0]       cell_wire_rd;
    logic             interior;

    function automatic logic [AW-1:0] cell_addr(input logic [7:0] x, input logic [7:0] y);
        return AW'(x) + AW'(y) * AW'(GRID_SIDE);
    endfunction

    function automatic logic off_grid(input logic [7:0] x, input logic [7:0] y);
        return (9'(x) >= 9'(GRID_SIDE)) || (9'(y) >= 9'(GRID_SIDE));
    endfunction

    gpw_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        // next anchor of the segment that starts at ax/ay
        kp1     = k_reg + AIW'(1);
        nx      = anch_x_reg[kp1[ANW-1:0]];
        ny      = anch_y_reg[kp1[ANW-1:0]];
        dx      = (nx >= ax_reg) ? (nx - ax_reg) : (ax_reg - nx);
        dy      = (ny >= ay_reg) ? (ny - ay_reg) : (ay_reg - ny);
        nlen    = (dx > dy) ? dx : dy;
        seg_bad = (dx != 8'd0) && (dy != 8'd0) && (dx != dy);

        // rectangle scan position
        px       = ax_reg + 8'(ox_reg);
        py       = ay_reg + 8'(oy_reg);
        p_last_y = (oy_reg + PW'(1)) == h_reg;
        p_done   = p_last_y && ((ox_reg + PW'(1)) == w_reg);

        cell_wire_rd = ram_rdata[15:8];
        interior     = (idx_reg != '0) && (idx_reg != (total_reg - TW'(1)));

        cnt_new = cnt_reg;
        ovf_new = ovf_reg;
        if (cnt_reg < AIW'(MAX_ANCHORS))
        begin
            cnt_new = cnt_reg + AIW'(1);
        end
        else
        begin
            ovf_new = 1'b1;
        end

        state_next     = state_reg;
        mode_next      = mode_reg;
        clr_next       = clr_reg;
        next_part_next = next_part_reg;
        next_wire_next = next_wire_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        k_next         = k_reg;
        idx_next       = idx_reg;
        total_next     = total_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        bad_next       = bad_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        fx_next        = fx_reg;
        fy_next        = fy_reg;
        xinc_next      = xinc_reg;
        xdec_next      = xdec_reg;
        yinc_next      = yinc_reg;
        ydec_next      = ydec_reg;
        rem_next       = rem_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        id_next        = id_reg;

        ram_we     = 1'b0;
        ram_addr   = cell_addr(cx_reg, cy_reg);
        ram_wdata  = '0;
        anch_we    = 1'b0;
        wire_end   = 1'b0;
        res_fire   = 1'b0;
        res_status = ST_OK;
        res_given  = '0;
        res_cp     = '0;
        res_cw     = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we   = 1'b1;
                ram_addr = clr_reg;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    ax_next = cell_x;
                    ay_next = cell_y;
                    w_next  = PW'(part_width);
                    h_next  = PW'(part_height);
                    id_next = wire_id;
                    ox_next = '0;
                    oy_next = '0;
                    unique case (op)
                        OP_PLACE:
                        begin
                            if (next_part_reg[8])
                            begin
                                res_fire   = 1'b1;
                                res_status = ST_NO_ID;
                            end
                            else if ((part_width == 5'd0) || (part_height == 5'd0) ||
                                     (7'(part_width) > 7'(MAX_PART)) ||
                                     (7'(part_height) > 7'(MAX_PART)) ||
                                     ((9'(cell_x) + 9'(part_width)) >= 9'(GRID_SIDE)) ||
                                     ((9'(cell_y) + 9'(part_height)) >= 9'(GRID_SIDE)))
                            begin
                                res_fire   = 1'b1;
                                res_status = ST_BLOCKED;
                            end
                            else
                            begin
                                state_next = S_PRD;
                            end
                        end

                        OP_ANCHOR:
                        begin
                            anch_we  = cnt_reg < AIW'(MAX_ANCHORS);
                            cnt_next = cnt_new;
                            ovf_next = ovf_new;
                            if (last_point)
                            begin
                                if ((wire_id == 8'd0) && next_wire_reg[8])
                                begin
                                    res_fire   = 1'b1;
                                    res_status = ST_NO_ID;
                                    wire_end   = 1'b1;
                                end
                                else if (ovf_new || (cnt_new < AIW'(2)))
                                begin
                                    res_fire   = 1'b1;
                                    res_status = ST_BAD_ANCHOR;
                                    wire_end   = 1'b1;
                                end
                                else
                                begin
                                    mode_next  = WM_MEASURE;
                                    total_next = '0;
                                    first_next = 1'b0;
                                    state_next = S_WLOAD;
                                end
                            end
                        end

                        OP_QUERY:
                        begin
                            if (off_grid(cell_x, cell_y))
                            begin
                                res_fire = 1'b1;
                            end
                            else
                            begin
                                state_next = S_QRD;
                            end
                        end

                        default:
                        begin
                        end
                    endcase
                end
            end

            S_PRD:
            begin
                ram_addr   = cell_addr(px, py);
                state_next = S_PEV;
            end

            S_PEV:
            begin
                if (ram_rdata != 16'd0)
                begin
                    res_fire   = 1'b1;
                    res_status = ST_BLOCKED;
                    state_next = S_IDLE;
                end
                else if (p_done)
                begin
                    ox_next    = '0;
                    oy_next    = '0;
                    state_next = S_PWR;
                end
                else
                begin
                    oy_next    = p_last_y ? '0 : oy_reg + PW'(1);
                    ox_next    = p_last_y ? ox_reg + PW'(1) : ox_reg;
                    state_next = S_PRD;
                end
            end

            S_PWR:
            begin
                ram_we    = 1'b1;
                ram_addr  = cell_addr(px, py);
                ram_wdata = {8'd0, next_part_reg[7:0]};
                oy_next   = p_last_y ? '0 : oy_reg + PW'(1);
                ox_next   = p_last_y ? ox_reg + PW'(1) : ox_reg;
                if (p_done)
                begin
                    res_fire       = 1'b1;
                    res_given      = next_part_reg[7:0];
                    next_part_next = next_part_reg + 9'd1;
                    state_next     = S_IDLE;
                end
            end

            S_QRD:
            begin
                ram_addr   = cell_addr(ax_reg, ay_reg);
                state_next = S_QEV;
            end

            S_QEV:
            begin
                res_fire   = 1'b1;
                res_cp     = ram_rdata[7:0];
                res_cw     = ram_rdata[15:8];
                state_next = S_IDLE;
            end

            S_WLOAD:
            begin
                ax_next   = anch_x_reg[0];
                ay_next   = anch_y_reg[0];
                k_next    = '0;
                idx_next  = '0;
                last_next = 1'b0;
                if ((mode_reg == WM_MEASURE) && off_grid(anch_x_reg[0], anch_y_reg[0]))
                begin
                    res_fire   = 1'b1;
                    res_status = ST_BAD_ANCHOR;
                    wire_end   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_WSEG;
                end
            end

            S_WSEG:
            begin
                if (kp1 < cnt_reg)
                begin
                    ax_next = nx;
                    ay_next = ny;
                    k_next  = kp1;
                    if (mode_reg == WM_MEASURE)
                    begin
                        if (seg_bad || off_grid(nx, ny))
                        begin
                            res_fire   = 1'b1;
                            res_status = ST_BAD_ANCHOR;
                            wire_end   = 1'b1;
                            state_next = S_IDLE;
                        end
                        total_next = total_reg + TW'(nlen);
                        if ((nlen != 8'd0) && !first_reg)
                        begin
                            fx_next    = ax_reg;
                            fy_next    = ay_reg;
                            first_next = 1'b1;
                        end
                    end
                    else
                    begin
                        cx_next   = ax_reg;
                        cy_next   = ay_reg;
                        xinc_next = nx > ax_reg;
                        xdec_next = nx < ax_reg;
                        yinc_next = ny > ay_reg;
                        ydec_next = ny < ay_reg;
                        rem_next  = nlen;
                        if (nlen != 8'd0)
                        begin
                            state_next = S_WRD;
                        end
                    end
                end
                else if (mode_reg == WM_MEASURE)
                begin
                    if (total_reg == '0)
                    begin
                        res_fire   = 1'b1;
                        res_status = ST_BAD_ANCHOR;
                        wire_end   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        total_next = total_reg + TW'(1);
                        if (id_reg != 8'd0)
                        begin
                            mode_next  = WM_CHECK;
                            bad_next   = 1'b0;
                            state_next = S_WLOAD;
                        end
                        else
                        begin
                            state_next = S_WIDA;
                        end
                    end
                end
                else if (!last_reg)
                begin
                    // final anchor itself is the last walked cell
                    cx_next    = ax_reg;
                    cy_next    = ay_reg;
                    xinc_next  = 1'b0;
                    xdec_next  = 1'b0;
                    yinc_next  = 1'b0;
                    ydec_next  = 1'b0;
                    rem_next   = 8'd1;
                    last_next  = 1'b1;
                    state_next = S_WRD;
                end
                else if (mode_reg == WM_CHECK)
                begin
                    if (bad_reg)
                    begin
                        res_fire   = 1'b1;
                        res_status = ST_CONFLICT;
                        wire_end   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        if (id_reg == 8'd0)
                        begin
                            id_next        = next_wire_reg[7:0];
                            next_wire_next = next_wire_reg + 9'd1;
                        end
                        mode_next  = WM_WRITE;
                        state_next = S_WLOAD;
                    end
                end
                else
                begin
                    res_fire   = 1'b1;
                    res_given  = id_reg;
                    wire_end   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_WIDA:
            begin
                ram_addr   = cell_addr(fx_reg, fy_reg);
                state_next = S_WIDB;
            end

            S_WIDB:
            begin
                if (cell_wire_rd != 8'd0)
                begin
                    id_next    = cell_wire_rd;
                    mode_next  = WM_CHECK;
                    bad_next   = 1'b0;
                    state_next = S_WLOAD;
                end
                else
                begin
                    // ax/ay hold the final anchor after the measure pass
                    ram_addr   = cell_addr(ax_reg, ay_reg);
                    state_next = S_WIDC;
                end
            end

            S_WIDC:
            begin
                id_next    = cell_wire_rd;
                mode_next  = WM_CHECK;
                bad_next   = 1'b0;
                state_next = S_WLOAD;
            end

            S_WRD:
            begin
                state_next = S_WEV;
            end

            S_WEV:
            begin
                if (mode_reg == WM_CHECK)
                begin
                    if ((id_reg != 8'd0) && (cell_wire_rd != 8'd0) && (cell_wire_rd != id_reg))
                    begin
                        bad_next = 1'b1;
                    end
                    if (interior && (ram_rdata != 16'd0))
                    begin
                        bad_next = 1'b1;
                    end
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_wdata = {id_reg, ram_rdata[7:0]};
                end
                cx_next  = xinc_reg ? cx_reg + 8'd1 : (xdec_reg ? cx_reg - 8'd1 : cx_reg);
                cy_next  = yinc_reg ? cy_reg + 8'd1 : (ydec_reg ? cy_reg - 8'd1 : cy_reg);
                rem_next = rem_reg - 8'd1;
                idx_next = idx_reg + TW'(1);
                state_next = (rem_reg == 8'd1) ? S_WSEG : S_WRD;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // anchor buffer is emptied once a wire is judged
        if (wire_end)
        begin
            cnt_next = '0;
            ovf_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            mode_reg      <= WM_MEASURE;
            clr_reg       <= '0;
            next_part_reg <= 9'd1;
            next_wire_reg <= 9'd1;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            k_reg         <= '0;
            idx_reg       <= '0;
            total_reg     <= '0;
            first_reg     <= 1'b0;
            last_reg      <= 1'b0;
            bad_reg       <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            clr_reg       <= clr_next;
            next_part_reg <= next_part_next;
            next_wire_reg <= next_wire_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            k_reg         <= k_next;
            idx_reg       <= idx_next;
            total_reg     <= total_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            bad_reg       <= bad_next;
            done_reg      <= res_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        fx_reg   <= fx_next;
        fy_reg   <= fy_next;
        xinc_reg <= xinc_next;
        xdec_reg <= xdec_next;
        yinc_reg <= yinc_next;
        ydec_reg <= ydec_next;
        rem_reg  <= rem_next;
        ox_reg   <= ox_next;
        oy_reg   <= oy_next;
        w_reg    <= w_next;
        h_reg    <= h_next;
        id_reg   <= id_next;
        if (res_fire)
        begin
            ok_reg     <= res_status == ST_OK;
            status_reg <= res_status;
            given_reg  <= (res_status == ST_OK) ? res_given : 8'd0;
            cp_reg     <= res_cp;
            cw_reg     <= res_cw;
        end
        if (anch_we)
        begin
            anch_x_reg[cnt_reg[ANW-1:0]] <= cell_x;
            anch_y_reg[cnt_reg[ANW-1:0]] <= cell_y;
        end
    end

    assign busy      = state_reg != S_IDLE;
    assign done      = done_reg;
    assign ok        = ok_reg;
    assign status    = status_reg;
    assign given_id  = given_reg;
    assign cell_part = cp_reg;
    assign cell_wire = cw_reg;

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (ok == (status == ST_OK)))
        else $error("ok disagrees with status");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ok) |-> (given_id == 8'd0))
        else $error("failed transaction reports an id");

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= AIW'(MAX_ANCHORS))
        else $error("anchor count beyond buffer depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !ram_we)
        else $error("cell write while idle");
`endif

endmodule
